// ===== rtl/sprite_column_vertical_scaler_assert.svh =====
// Assertion macros for the sprite column vertical scaler.
// Needs nothing else. The file that asserts supplies the clock and the reset.
`ifndef SPRITE_COLUMN_VERTICAL_SCALER_ASSERT_SVH
`define SPRITE_COLUMN_VERTICAL_SCALER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SCVS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaler assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SCVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaler assertion failed");

`endif

// ===== rtl/scvs_pkg.sv =====
// Shared types and constants for the sprite column vertical scaler.
// Has no dependencies. The top level uses it.
package scvs_pkg;

    // Source column geometry.
    localparam int SOURCE_ROWS = 64;
    localparam int SRC_SHIFT   = 6;
    localparam int MAX_RESULTS = 8;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SCALED_HEIGHT = 2'd0;
    localparam logic [1:0] REG_VIEW_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH     = 2'd2;

    // Register reset values.
    localparam logic [9:0] RST_SCALED_HEIGHT = 10'd64;
    localparam logic [7:0] RST_VIEW_HEIGHT   = 8'd144;
    localparam logic [7:0] RST_ROW_PITCH     = 8'd40;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_CLIP,
        ST_ADDR,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/sprite_column_vertical_scaler.sv =====
// An accepted texel word steps through the LO, HI, CLIP and ADDR states of the
// multiplier sequencer; EMIT then gives one row write a cycle while the receiver does
// not stall, for n visible rows (at most eight). With none, CLIP returns to idle. The input stalls until idle.
// Reset (synchronous, active low) clears the sequencer and the output valid,
// and loads the registers with height 64, view 144 and pitch 40.
// Depends on scvs_pkg and sprite_column_vertical_scaler_assert.svh.
`include "sprite_column_vertical_scaler_assert.svh"

module sprite_column_vertical_scaler #(
    parameter int MAX_HEIGHT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    // Texel input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_source_row,
    input  logic [7:0]  i_pixel_value,
    input  logic [15:0] i_column_base,
    input  logic [7:0]  i_bit_mask,
    // Row write output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_dest_address,
    output logic [7:0]  o_screen_row,
    output logic [7:0]  o_write_value,
    output logic [7:0]  o_write_mask,
    output logic        o_last_write
);

    // Configuration registers.
    logic [9:0] r_scaled_height;
    logic [7:0] r_view_height;
    logic [7:0] r_row_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled_height <= scvs_pkg::RST_SCALED_HEIGHT;
            r_view_height   <= scvs_pkg::RST_VIEW_HEIGHT;
            r_row_pitch     <= scvs_pkg::RST_ROW_PITCH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scvs_pkg::REG_SCALED_HEIGHT: r_scaled_height <= i_cfg_data;
                scvs_pkg::REG_VIEW_HEIGHT:   r_view_height   <= i_cfg_data[7:0];
                scvs_pkg::REG_ROW_PITCH:     r_row_pitch     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    scvs_pkg::t_state r_state, n_state;

    logic        in_accept;
    logic        slot_free;
    logic        emit_last;
    logic        span_empty;

    // Captured texel word.
    logic [5:0]  r_src;
    logic [7:0]  r_val;
    logic [15:0] r_base;
    logic [7:0]  r_mask;

    // Row span and address walk.
    logic [9:0]  r_lo;
    logic [10:0] r_hi;
    logic [7:0]  r_row;
    logic [7:0]  r_stop;
    logic [15:0] r_addr;
    logic [2:0]  r_cnt;

    assign in_accept = i_valid && !o_stall;
    assign slot_free = !o_valid || !i_stall;

    // Height saturation and centring offset, truncated toward zero.
    logic [9:0]         h_sat;
    logic signed [11:0] diff;
    logic signed [11:0] top;

    always_comb begin
        if ({1'b0, r_scaled_height} > 11'(MAX_HEIGHT)) begin
            h_sat = 10'(MAX_HEIGHT);
        end else begin
            h_sat = r_scaled_height;
        end
        diff = $signed({4'b0, r_view_height}) - $signed({2'b0, h_sat});
        top  = (diff + $signed({11'b0, diff[11]})) >>> 1;
    end

    // Shared multiplier; operands chosen by the sequencer state.
    logic [10:0] mul_a;
    logic [9:0]  mul_b;
    logic [20:0] mul_p;

    assign mul_p = {10'b0, mul_a} * {11'b0, mul_b};

    // Clipping of the span to the view.
    logic signed [11:0] first_s;
    logic signed [11:0] stop_s;
    logic signed [11:0] first_c;
    logic signed [11:0] stop_c;
    logic signed [11:0] vh_s;

    always_comb begin
        vh_s    = $signed({4'b0, r_view_height});
        first_s = $signed({2'b0, r_lo}) + top;
        stop_s  = $signed({1'b0, r_hi}) + top;
        first_c = (first_s < 12'sd0) ? 12'sd0 : first_s;
        stop_c  = (stop_s > vh_s) ? vh_s : stop_s;
        span_empty = (first_c >= stop_c);
    end

    // The last write of a texel ends the span or fills the result budget.
    assign emit_last = ({1'b0, r_row} + 9'd1 == {1'b0, r_stop})
                    || (r_cnt == 3'(scvs_pkg::MAX_RESULTS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scvs_pkg::ST_IDLE: if (in_accept) n_state = scvs_pkg::ST_LO;
            scvs_pkg::ST_LO:   n_state = scvs_pkg::ST_HI;
            scvs_pkg::ST_HI:   n_state = scvs_pkg::ST_CLIP;
            scvs_pkg::ST_CLIP: begin
                n_state = span_empty ? scvs_pkg::ST_IDLE : scvs_pkg::ST_ADDR;
            end
            scvs_pkg::ST_ADDR: n_state = scvs_pkg::ST_EMIT;
            scvs_pkg::ST_EMIT: if (slot_free && emit_last) n_state = scvs_pkg::ST_IDLE;
            default:           n_state = scvs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input stall and multiplier operands.
    always_comb begin
        o_stall = (r_state != scvs_pkg::ST_IDLE);
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            scvs_pkg::ST_LO: begin
                mul_a = {5'b0, r_src};
                mul_b = h_sat;
            end
            scvs_pkg::ST_HI: begin
                mul_a = {4'b0, {1'b0, r_src} + 7'd1};
                mul_b = h_sat;
            end
            scvs_pkg::ST_ADDR: begin
                mul_a = {3'b0, r_row};
                mul_b = {2'b0, r_row_pitch};
            end
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scvs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            scvs_pkg::ST_IDLE: begin
                if (in_accept) begin
                    r_src  <= i_source_row;
                    r_val  <= i_pixel_value;
                    r_base <= i_column_base;
                    r_mask <= i_bit_mask;
                end
            end
            scvs_pkg::ST_LO: r_lo <= mul_p[scvs_pkg::SRC_SHIFT +: 10];
            scvs_pkg::ST_HI: r_hi <= mul_p[scvs_pkg::SRC_SHIFT +: 11];
            scvs_pkg::ST_CLIP: begin
                r_row  <= first_c[7:0];
                r_stop <= stop_c[7:0];
                r_cnt  <= '0;
            end
            scvs_pkg::ST_ADDR: r_addr <= r_base + mul_p[15:0];
            scvs_pkg::ST_EMIT: begin
                if (slot_free) begin
                    r_row  <= r_row + 8'd1;
                    r_addr <= r_addr + {8'b0, r_row_pitch};
                    r_cnt  <= r_cnt + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // Output word register; it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (slot_free) begin
            o_valid <= (r_state == scvs_pkg::ST_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && r_state == scvs_pkg::ST_EMIT) begin
            o_dest_address <= r_addr;
            o_screen_row   <= r_row;
            o_write_value  <= r_val;
            o_write_mask   <= r_mask;
            o_last_write   <= emit_last;
        end
    end

    // The walk never reaches the end of the span while emitting.
    `SCVS_ASSERT_SAME(a_row_in_span, i_clk, i_rst_n,
        r_state == scvs_pkg::ST_EMIT, r_row < r_stop)
    // An accepted texel moves the sequencer into its LO state.
    `SCVS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        in_accept, r_state == scvs_pkg::ST_LO)
    // A write issued into a free slot shows up as a valid word.
    `SCVS_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n,
        r_state == scvs_pkg::ST_EMIT && slot_free, o_valid)

endmodule
